>>> rtl/pbcp_pkg.sv
// shared types and constants for the pinned block cache policy
package pbcp_pkg;

  localparam int DEPTH = 64;
  localparam int BLOCK_W = 32;
  localparam int PIN_W = 16;
  localparam int SLOT_W = 6;
  localparam int STATUS_W = 3;
  localparam int CAP_W = 7;
  localparam int USED_W = $clog2(DEPTH + 1);

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [USED_W-1:0] DEPTH_USED = USED_W'(DEPTH);

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS_LOADED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    logic [PIN_W-1:0] pins;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RELEASE,
    OP_HIT,
    OP_APPEND,
    OP_EVICT
  } op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;
    op_t op;
    entry_t fill;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_EXEC
  } state_t;

  function automatic logic [PIN_W-1:0] pin_inc(input logic [PIN_W-1:0] p);
    pin_inc = (p == PIN_MAX) ? p : p + PIN_W'(1);
  endfunction

endpackage

>>> rtl/pbcp_cell.sv
// one queue position: entry storage, key compare and neighbor moves
module pbcp_cell (
  input  logic              clk,
  input  logic              rst,
  input  pbcp_pkg::cell_cmd_t cmd,
  input  pbcp_pkg::entry_t  left_entry,
  input  logic              left_valid,
  input  logic              left_match,
  input  pbcp_pkg::entry_t  right_entry,
  input  logic              right_valid,
  output pbcp_pkg::entry_t  entry,
  output logic              valid,
  output logic              match
);
  import pbcp_pkg::*;

  entry_t entry_next;
  logic   valid_next;
  logic   match_next;

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    match_next = match;
    if (cmd.cmp_en) begin
      match_next = valid && (entry.block == cmd.fill.block);
    end
    unique case (cmd.op)
      OP_RELEASE: begin
        if (match && entry.pins != '0) begin
          entry_next.pins = entry.pins - PIN_W'(1);
        end
      end
      OP_HIT: begin
        // hit entry trades places with its tail-side neighbor
        if (match && right_valid) begin
          entry_next = right_entry;
        end else if (match) begin
          entry_next.pins = pin_inc(entry.pins);
        end else if (left_match && valid) begin
          entry_next = left_entry;
          entry_next.pins = pin_inc(left_entry.pins);
        end
      end
      OP_APPEND: begin
        if (!valid && left_valid) begin
          entry_next = cmd.fill;
          valid_next = 1'b1;
        end
      end
      OP_EVICT: begin
        // whole queue moves one toward the head, last valid cell takes the new block
        if (valid && right_valid) begin
          entry_next = right_entry;
        end else if (valid) begin
          entry_next = cmd.fill;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      valid <= valid_next;
      match <= match_next;
    end
  end

endmodule

>>> rtl/pinned_block_cache_policy.sv
// top level: controller, capacity register, output register and the row of cells
// an accepted beat goes through accept, compare and update before its result beat
// one item at a time: the next beat waits for the compare then update pass over the cells
// the next beat is taken while a finished result still waits on the output side
// reset: synchronous, empties the queue (all cells invalid) and sets capacity to 64
// the entry payload in the cells is not cleared; an invalid cell is never matched
module pinned_block_cache_policy (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [pbcp_pkg::CAP_W-1:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] block_number
  input  logic [0:0]  s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [5:0] slot, [37:6] evicted_block, [39:38] zero
  output logic [3:0]  m_axis_tuser   // [2:0] status, [3] evicted_valid
);
  import pbcp_pkg::*;

  state_t state, state_next;

  logic [CAP_W-1:0]   capacity;
  logic [USED_W-1:0]  used, used_next;
  logic               cmd_reg;
  logic [BLOCK_W-1:0] key;

  cell_cmd_t cell_cmd;
  entry_t    cell_entry [DEPTH];
  logic      cell_valid [DEPTH];
  logic      cell_match [DEPTH];

  logic [USED_W-1:0]   cap_eff;
  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic                full;
  logic                out_free;
  logic                fire;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_ev_valid;
  logic [BLOCK_W-1:0]  res_ev_block;
  op_t                 res_op;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  // capacity clamped into 1 .. DEPTH
  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = USED_W'(1);
    end else if (USED_W'(capacity) > DEPTH_USED) begin
      cap_eff = DEPTH_USED;
    end else begin
      cap_eff = USED_W'(capacity);
    end
  end

  // at most one cell matches, so an or over the row selects its slot
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit = hit | cell_match[i];
      hit_slot = hit_slot | (cell_match[i] ? cell_entry[i].slot : '0);
    end
  end

  assign full = used >= cap_eff;

  always_comb begin
    res_status = ST_NOT_FOUND;
    res_slot = '0;
    res_ev_valid = 1'b0;
    res_ev_block = '0;
    res_op = OP_NONE;
    used_next = used;
    if (cmd_reg == CMD_RELEASE) begin
      if (hit) begin
        res_status = ST_RELEASED;
        res_slot = hit_slot;
        res_op = OP_RELEASE;
      end
    end else if (hit) begin
      res_status = ST_HIT;
      res_slot = hit_slot;
      res_op = OP_HIT;
    end else if (full) begin
      if (cell_entry[0].pins != '0) begin
        res_status = ST_NO_ROOM;
      end else begin
        res_status = ST_MISS_LOADED;
        res_slot = cell_entry[0].slot;
        res_ev_valid = 1'b1;
        res_ev_block = cell_entry[0].block;
        res_op = OP_EVICT;
      end
    end else begin
      res_status = ST_MISS_LOADED;
      res_slot = used[SLOT_W-1:0];
      res_op = OP_APPEND;
      used_next = used + USED_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_axis_tvalid) state_next = S_COMPARE;
      S_COMPARE: state_next = S_EXEC;
      S_EXEC:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    fire = 1'b0;
    cell_cmd.cmp_en = 1'b0;
    cell_cmd.op = OP_NONE;
    cell_cmd.fill.block = key;
    cell_cmd.fill.pins = PIN_W'(1);
    cell_cmd.fill.slot = res_slot;
    unique case (state)
      S_IDLE:    s_axis_tready = 1'b1;
      S_COMPARE: cell_cmd.cmp_en = 1'b1;
      S_EXEC: begin
        fire = out_free;
        cell_cmd.op = out_free ? res_op : OP_NONE;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t l_entry, r_entry;
    logic   l_valid, l_match, r_valid;
    if (i == 0) begin : g_head
      assign l_entry = '0;
      assign l_valid = 1'b1;
      assign l_match = 1'b0;
    end else begin : g_left
      assign l_entry = cell_entry[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_match = cell_match[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_right
      assign r_entry = cell_entry[i+1];
      assign r_valid = cell_valid[i+1];
    end
    pbcp_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cell_cmd),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_match  (l_match),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .match       (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key <= s_axis_tdata;
      cmd_reg <= s_axis_tuser[0];
    end
    if (fire) begin
      m_axis_tdata <= {2'b00, res_ev_block, res_slot};
      m_axis_tuser <= {res_ev_valid, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= CAP_RESET;
      used <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (fire) begin
        used <= used_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
